[rtl/integer_printf_formatter_defines.svh]
// integer_printf_formatter_defines.svh: assertion macros for the formatter checker
// expects signals named clock and reset in the scope where a macro is used
`ifndef INTEGER_PRINTF_FORMATTER_DEFINES_SVH
`define INTEGER_PRINTF_FORMATTER_DEFINES_SVH

// concurrent assertion on the rising clock, off during reset
`define IPF_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ipf check failed");

// same with a caller supplied message
`define IPF_ASSERT_MSG(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`endif

[rtl/ipf_pkg.sv]
// ipf_pkg: constants, conversion codes and character helpers of the integer formatter
// no dependencies
package ipf_pkg;

   // conversion codes
   localparam logic [2:0] CMD_SDEC = 3'd0;
   localparam logic [2:0] CMD_UDEC = 3'd1;
   localparam logic [2:0] CMD_OCT  = 3'd2;
   localparam logic [2:0] CMD_HEXL = 3'd3;
   localparam logic [2:0] CMD_HEXU = 3'd4;

   // sign mode codes
   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_SPACE = 2'd1;
   localparam logic [1:0] SIGN_PLUS  = 2'd2;

   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] MAX_WIDTH     = 7'd64;
   localparam logic [CNT_W-1:0] MAX_PRECISION = 7'd32;
   localparam logic [CNT_W-1:0] MAX_RESULTS   = 7'd64;
   localparam logic [CNT_W-1:0] DABBLE_STEPS  = 7'd64;

   // enough digit slots for 64-bit octal; decimal needs 20, hex 16
   localparam int NUM_DIGITS = 22;
   localparam int DIG_IDX_W  = 5;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_A_LO  = 8'h61;
   localparam logic [7:0] CHAR_A_UP  = 8'h41;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base_c;
      base_c = upper ? CHAR_A_UP : CHAR_A_LO;
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + {4'b0, d};
      end else begin
         digit_char = base_c + {4'b0, d} - 8'd10;
      end
   endfunction

endpackage

[rtl/ipf_if.sv]
// ipf_req_if / ipf_rsp_if: valid/ready channels of the integer formatter
// no dependencies
interface ipf_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        cmd;
   logic [63:0]       number;
   logic              left_justify;
   logic [1:0]        sign_mode;
   logic              alternate_form;
   logic              zero_fill;
   logic [6:0]        min_width;
   logic signed [6:0] min_digits;

   modport source (
      output valid, cmd, number, left_justify, sign_mode, alternate_form,
             zero_fill, min_width, min_digits,
      input  ready
   );
   modport sink (
      input  valid, cmd, number, left_justify, sign_mode, alternate_form,
             zero_fill, min_width, min_digits,
      output ready
   );
endinterface

interface ipf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, out_char, last_char, input ready);
   modport sink   (input valid, out_char, last_char, output ready);
endinterface

[rtl/integer_printf_formatter.sv]
// integer_printf_formatter: printf-style integer conversion, one character per transaction
// depends on ipf_pkg and the channel interfaces in ipf_if.sv
//
// Formats one 64-bit value per request (signed/unsigned decimal, octal, hex) with sign,
// alternate prefix, precision and field width, and streams the text out one character
// per rsp transaction, last_char marking the final one; an unused conversion code or an
// empty result produces nothing. One request at a time: req ready is high only while the
// sequencer is idle. Decimal goes through a shared shift-and-add-3 unit, one bit per cycle;
// then a scan finds the leading digit, a plan state works out the padding, and output runs
// at one character per cycle while the rsp slot is free, in six output sections. Octal and
// hex skip the shift-and-add-3 conversion. An item produces at most 64 characters.
module integer_printf_formatter (
   input logic clock,
   input logic reset,
   ipf_req_if.sink   req_chan,
   ipf_rsp_if.source rsp_chan
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_CONV  = 10'b0000000010,
      S_SCAN  = 10'b0000000100,
      S_PLAN  = 10'b0000001000,
      S_LEAD  = 10'b0000010000,
      S_SIGN  = 10'b0000100000,
      S_PFX   = 10'b0001000000,
      S_ZERO  = 10'b0010000000,
      S_DIGIT = 10'b0100000000,
      S_TRAIL = 10'b1000000000
   } state_type;

   localparam int CW = ipf_pkg::CNT_W;
   localparam int NDIG = ipf_pkg::NUM_DIGITS;
   localparam int IW = ipf_pkg::DIG_IDX_W;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [63:0]   mag_ff, mag_in;
   logic [3:0]    digit_ff [NDIG];
   logic [3:0]    digit_in [NDIG];

   // per-item settings
   logic          is_dec_ff, is_oct_ff, upper_ff, alt_ff, zfill_ff, left_ff;
   logic [7:0]    sign_char_ff;
   logic [CW-1:0] width_ff, prec_ff;
   logic [IW-1:0] raw_len_ff;
   logic [CW-1:0] pad_ff, trail_ff;
   logic          xpre_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff;
   logic          rsp_last_ff;

   logic          req_fire, cmd_ok, slot_free;
   logic          negative;
   logic [63:0]   mag_load;
   logic [7:0]    sign_load;
   logic [IW-1:0] rd_idx;
   logic [3:0]    rd_digit;
   logic          scan_done;

   logic          oct_alt, hex_alt, has_sign;
   logic [CW-1:0] raw_w, pad0, len, fill, total, plan_lead, plan_trail, plan_pad;

   logic          ph_active, emit;
   state_type     ph_next;
   logic [CW-1:0] ph_cnt;
   logic [7:0]    ph_char;

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign req_fire           = req_chan.valid && (state_ff == S_IDLE);
   assign cmd_ok             = (req_chan.cmd <= ipf_pkg::CMD_HEXU);
   assign slot_free          = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_char  = rsp_char_ff;
   assign rsp_chan.last_char = rsp_last_ff;

   // accept-time sign handling
   always_comb begin
      negative = (req_chan.cmd == ipf_pkg::CMD_SDEC) && req_chan.number[63];
      mag_load = negative ? (64'd0 - req_chan.number) : req_chan.number;
      sign_load = 8'd0;
      if (negative) begin
         sign_load = ipf_pkg::CHAR_MINUS;
      end else if (req_chan.cmd == ipf_pkg::CMD_SDEC) begin
         case (req_chan.sign_mode)
            ipf_pkg::SIGN_SPACE: sign_load = ipf_pkg::CHAR_SPACE;
            ipf_pkg::SIGN_PLUS:  sign_load = ipf_pkg::CHAR_PLUS;
            default:             sign_load = 8'd0;
         endcase
      end
   end

   // single digit read port, shared by scan and digit output
   assign rd_idx = cnt_ff[IW-1:0] - IW'(1);
   always_comb begin
      rd_digit = 4'd0;
      for (int i = 0; i < NDIG; i++) begin
         if (rd_idx == IW'(i)) begin
            rd_digit = digit_ff[i];
         end
      end
   end
   assign scan_done = (cnt_ff == '0) || (rd_digit != 4'd0);

   // padding plan
   always_comb begin
      raw_w    = {{(CW-IW){1'b0}}, raw_len_ff};
      oct_alt  = is_oct_ff && alt_ff;
      hex_alt  = !is_dec_ff && !is_oct_ff && alt_ff && (raw_len_ff != '0);
      has_sign = (sign_char_ff != 8'd0);
      pad0     = (raw_w < prec_ff) ? (prec_ff - raw_w) : {{(CW-1){1'b0}}, oct_alt};
      len      = raw_w + pad0 + {{(CW-2){1'b0}}, hex_alt, 1'b0}
                 + {{(CW-1){1'b0}}, has_sign};
      fill     = (width_ff > len) ? (width_ff - len) : '0;
      total    = len + fill;
      if (total > ipf_pkg::MAX_RESULTS) begin
         total = ipf_pkg::MAX_RESULTS;
      end
      plan_lead  = (!zfill_ff && !left_ff) ? fill : '0;
      plan_trail = (!zfill_ff && left_ff) ? fill : '0;
      plan_pad   = zfill_ff ? (pad0 + fill) : pad0;
   end

   // output sections
   always_comb begin
      ph_active = 1'b1;
      ph_next   = S_IDLE;
      ph_cnt    = '0;
      ph_char   = ipf_pkg::CHAR_SPACE;
      unique case (state_ff)
         S_LEAD: begin
            ph_next = S_SIGN;
            ph_cnt  = {{(CW-1){1'b0}}, (sign_char_ff != 8'd0)};
         end
         S_SIGN: begin
            ph_next = S_PFX;
            ph_cnt  = {{(CW-2){1'b0}}, xpre_ff, 1'b0};
            ph_char = sign_char_ff;
         end
         S_PFX: begin
            ph_next = S_ZERO;
            ph_cnt  = pad_ff;
            if (cnt_ff == CW'(2)) begin
               ph_char = ipf_pkg::CHAR_ZERO;
            end else begin
               ph_char = upper_ff ? ipf_pkg::CHAR_X_UP : ipf_pkg::CHAR_X_LO;
            end
         end
         S_ZERO: begin
            ph_next = S_DIGIT;
            ph_cnt  = {{(CW-IW){1'b0}}, raw_len_ff};
            ph_char = ipf_pkg::CHAR_ZERO;
         end
         S_DIGIT: begin
            ph_next = S_TRAIL;
            ph_cnt  = trail_ff;
            ph_char = ipf_pkg::digit_char(rd_digit, upper_ff);
         end
         S_TRAIL: begin
            ph_next = S_IDLE;
         end
         default: begin
            ph_active = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      remain_in = remain_ff;
      emit      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && cmd_ok) begin
               if (req_chan.cmd <= ipf_pkg::CMD_UDEC) begin
                  state_in = S_CONV;
                  cnt_in   = ipf_pkg::DABBLE_STEPS;
               end else begin
                  state_in = S_SCAN;
                  cnt_in   = CW'(NDIG);
               end
            end
         end
         S_CONV: begin
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_SCAN;
               cnt_in   = CW'(NDIG);
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_PLAN;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         S_PLAN: begin
            state_in  = S_LEAD;
            cnt_in    = plan_lead;
            remain_in = total;
         end
         default: begin
            if (ph_active) begin
               if ((cnt_ff == '0) || (remain_ff == '0)) begin
                  state_in = ph_next;
                  cnt_in   = ph_cnt;
               end else if (slot_free) begin
                  emit      = 1'b1;
                  cnt_in    = cnt_ff - CW'(1);
                  remain_in = remain_ff - CW'(1);
               end
            end else begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // digit register: load for octal/hex, shift-and-add-3 for decimal
   always_comb begin
      logic [3:0]  adj [NDIG];
      logic [65:0] oct_src;
      logic [87:0] hex_src;
      oct_src = {2'b0, req_chan.number};
      hex_src = {24'b0, req_chan.number};
      mag_in  = mag_ff;
      for (int i = 0; i < NDIG; i++) begin
         digit_in[i] = digit_ff[i];
         adj[i]      = (digit_ff[i] >= 4'd5) ? (digit_ff[i] + 4'd3) : digit_ff[i];
      end
      if (req_fire) begin
         mag_in = mag_load;
         for (int i = 0; i < NDIG; i++) begin
            if (req_chan.cmd == ipf_pkg::CMD_OCT) begin
               digit_in[i] = {1'b0, oct_src[3*i +: 3]};
            end else if (req_chan.cmd >= ipf_pkg::CMD_HEXL) begin
               digit_in[i] = hex_src[4*i +: 4];
            end else begin
               digit_in[i] = 4'd0;
            end
         end
      end else if (state_ff == S_CONV) begin
         mag_in = {mag_ff[62:0], 1'b0};
         digit_in[0] = {adj[0][2:0], mag_ff[63]};
         for (int i = 1; i < NDIG; i++) begin
            digit_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      remain_ff <= remain_in;
      mag_ff    <= mag_in;
      for (int i = 0; i < NDIG; i++) begin
         digit_ff[i] <= digit_in[i];
      end
      if (req_fire) begin
         is_dec_ff    <= (req_chan.cmd <= ipf_pkg::CMD_UDEC);
         is_oct_ff    <= (req_chan.cmd == ipf_pkg::CMD_OCT);
         upper_ff     <= (req_chan.cmd == ipf_pkg::CMD_HEXU);
         alt_ff       <= req_chan.alternate_form;
         zfill_ff     <= req_chan.zero_fill;
         left_ff      <= req_chan.left_justify;
         sign_char_ff <= sign_load;
         width_ff     <= (req_chan.min_width > ipf_pkg::MAX_WIDTH) ?
                         ipf_pkg::MAX_WIDTH : req_chan.min_width;
         // negative precision means the default of one digit
         if (req_chan.min_digits[6]) begin
            prec_ff <= CW'(1);
         end else if ({1'b0, req_chan.min_digits[5:0]} > ipf_pkg::MAX_PRECISION) begin
            prec_ff <= ipf_pkg::MAX_PRECISION;
         end else begin
            prec_ff <= {1'b0, req_chan.min_digits[5:0]};
         end
      end
      if ((state_ff == S_SCAN) && scan_done) begin
         raw_len_ff <= cnt_ff[IW-1:0];
      end
      if (state_ff == S_PLAN) begin
         pad_ff   <= plan_pad;
         trail_ff <= plan_trail;
         xpre_ff  <= hex_alt;
      end
      if (emit) begin
         rsp_char_ff <= ph_char;
         rsp_last_ff <= (remain_ff == CW'(1));
      end
   end

endmodule

[rtl/ipf_checker.sv]
// ipf_checker: port-level checks of integer_printf_formatter, attached by bind
// depends on ipf_pkg and integer_printf_formatter_defines.svh
`include "integer_printf_formatter_defines.svh"

module ipf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_char
);

   // a valid conversion keeps the block busy
   `IPF_ASSERT(busy_after_accept, req_valid && req_ready && (req_cmd <= ipf_pkg::CMD_HEXU) |=> !req_ready)

   // once idle, only the final character may still be waiting
   `IPF_ASSERT(idle_holds_only_last, req_ready && rsp_valid |-> rsp_last_char)

   // more characters follow a non-final transaction
   `IPF_ASSERT_MSG(busy_until_last, rsp_valid && rsp_ready && !rsp_last_char |=> !req_ready, "ipf ready before last character")

   `IPF_ASSERT(rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_char))

endmodule

bind integer_printf_formatter ipf_checker u_ipf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_cmd       (req_chan.cmd),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_char  (rsp_chan.out_char),
   .rsp_last_char (rsp_chan.last_char)
);

[dv/testbench.sv]
// testbench: self-checking bench for integer_printf_formatter
// depends on ipf_pkg (rtl/ipf_pkg.sv) and the channel interfaces in rtl/ipf_if.sv
`timescale 1ns / 1ps

module testbench;

   localparam logic [1:0] SIGN_UNUSED = 2'd3;
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
   localparam int RANDOM_PER_PHASE = 82;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 200;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [63:0]       number;
      logic              left_justify;
      logic [1:0]        sign_mode;
      logic              alternate_form;
      logic              zero_fill;
      logic [6:0]        min_width;
      logic signed [6:0] min_digits;
   } fmt_req_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ipf_req_if req_if();
   ipf_rsp_if rsp_if();

   integer_printf_formatter dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   char_rec_type pending_text[$];
   int error_count = 0;
   int chars_checked = 0;
   int conversions_sent = 0;
   int ignored_sent = 0;
   int cycle_count = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   fmt_req_type directed_reqs[$];
   bit          directed_typed[$];
   string       directed_text[$];

   function automatic string with_char(input string s, input logic [7:0] ch);
      return $sformatf("%s%c", s, ch);
   endfunction

   // formatted text that one request should produce, empty when nothing comes out
   function automatic string format_expected(input fmt_req_type r);
      logic [63:0] mag;
      logic [3:0]  digs [64];
      logic [7:0]  sign_ch;
      logic [7:0]  ch;
      int unsigned width, prec, base, raw_len, pad_len, length, lead, trail;
      bit oct_alt, hex_alt, upper;
      string text;
      text = "";
      if (r.cmd > ipf_pkg::CMD_HEXU) return text;
      width = 32'((r.min_width > ipf_pkg::MAX_WIDTH) ? ipf_pkg::MAX_WIDTH : r.min_width);
      if (r.min_digits[6]) prec = 1;
      else prec = 32'((r.min_digits > ipf_pkg::MAX_PRECISION) ? ipf_pkg::MAX_PRECISION
                                                               : r.min_digits);
      base = (r.cmd == ipf_pkg::CMD_OCT) ? 8 :
             ((r.cmd == ipf_pkg::CMD_HEXL || r.cmd == ipf_pkg::CMD_HEXU) ? 16 : 10);
      oct_alt = (r.cmd == ipf_pkg::CMD_OCT) && r.alternate_form;
      hex_alt = (base == 16) && r.alternate_form;
      upper = (r.cmd == ipf_pkg::CMD_HEXU);
      mag = r.number;
      sign_ch = 8'h00;
      if (r.cmd == ipf_pkg::CMD_SDEC) begin
         if (mag[63]) begin
            sign_ch = ipf_pkg::CHAR_MINUS;
            mag = 64'd0 - mag;
         end else if (r.sign_mode == ipf_pkg::SIGN_SPACE) begin
            sign_ch = ipf_pkg::CHAR_SPACE;
         end else if (r.sign_mode == ipf_pkg::SIGN_PLUS) begin
            sign_ch = ipf_pkg::CHAR_PLUS;
         end
      end
      raw_len = 0;
      while (mag != 64'd0) begin
         digs[raw_len] = 4'(mag % 64'(base));
         mag = mag / 64'(base);
         raw_len++;
      end
      // octal alternate form adds a zero only if precision did not already supply one
      pad_len = (raw_len < prec) ? prec - raw_len : (oct_alt ? 1 : 0);
      length = raw_len + pad_len;
      if (hex_alt && raw_len != 0) length += 2;
      if (sign_ch != 8'h00) length += 1;
      lead = 0;
      trail = 0;
      if (length < width) begin
         if (r.zero_fill) pad_len += width - length;
         else if (!r.left_justify) lead = width - length;
         else trail = width - length;
      end
      for (int i = 0; i < lead; i++) text = with_char(text, ipf_pkg::CHAR_SPACE);
      if (sign_ch != 8'h00) text = with_char(text, sign_ch);
      if (hex_alt && raw_len != 0) begin
         text = with_char(text, ipf_pkg::CHAR_ZERO);
         text = with_char(text, upper ? ipf_pkg::CHAR_X_UP : ipf_pkg::CHAR_X_LO);
      end
      for (int i = 0; i < pad_len; i++) text = with_char(text, ipf_pkg::CHAR_ZERO);
      for (int i = raw_len - 1; i >= 0; i--) begin
         if (digs[i] < 4'd10) ch = ipf_pkg::CHAR_ZERO + 8'(digs[i]);
         else ch = (upper ? ipf_pkg::CHAR_A_UP : ipf_pkg::CHAR_A_LO) + 8'(digs[i]) - 8'd10;
         text = with_char(text, ch);
      end
      for (int i = 0; i < trail; i++) text = with_char(text, ipf_pkg::CHAR_SPACE);
      return text;
   endfunction

   function automatic void queue_text(input string s);
      char_rec_type rec;
      int n;
      n = (s.len() > ipf_pkg::MAX_RESULTS) ? ipf_pkg::MAX_RESULTS : s.len();
      for (int i = 0; i < n; i++) begin
         rec.ch = s[i];
         rec.last = (i == n - 1);
         pending_text.push_back(rec);
      end
   endfunction

   function automatic void add_case(input logic [2:0] cmd, input logic [63:0] number,
                                    input int left, input logic [1:0] smode, input int alt,
                                    input int zfill, input int width, input int prec,
                                    input int typed, input string golden);
      fmt_req_type r;
      r.cmd = cmd;
      r.number = number;
      r.left_justify = 1'(left);
      r.sign_mode = smode;
      r.alternate_form = 1'(alt);
      r.zero_fill = 1'(zfill);
      r.min_width = 7'(width);
      r.min_digits = 7'(prec);
      directed_reqs.push_back(r);
      directed_typed.push_back(1'(typed));
      directed_text.push_back(golden);
   endfunction

   function automatic fmt_req_type random_request();
      fmt_req_type r;
      int pick;
      r.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      pick = $urandom_range(0, 9);
      case (pick)
         0: r.number = 64'd0;
         1: r.number = 64'($urandom_range(0, 20));
         2: r.number = 64'd0 - 64'($urandom_range(1, 1000));
         3: r.number = 64'd1 << $urandom_range(0, 63);
         4: r.number = {1'b1, 63'd0} | 64'($urandom_range(0, 1));
         5: r.number = 64'($urandom_range(0, 99999));
         default: r.number = {$urandom, $urandom};
      endcase
      r.left_justify = 1'($urandom_range(0, 1));
      r.sign_mode = 2'($urandom_range(0, 3));
      r.alternate_form = 1'($urandom_range(0, 1));
      r.zero_fill = ($urandom_range(0, 99) < 30);
      r.min_width = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 24))
                                                  : 7'($urandom_range(25, 127));
      pick = $urandom_range(0, 99);
      if (pick < 25) r.min_digits = -7'sd1;
      else if (pick < 35) r.min_digits = 7'(int'($urandom_range(0, 62)) - 64);
      else if (pick < 85) r.min_digits = 7'($urandom_range(0, 12));
      else r.min_digits = 7'($urandom_range(13, 63));
      return r;
   endfunction

   // offers one request, with random idle cycles first, and records its text on acceptance
   task automatic send_format(input fmt_req_type r, input bit typed, input string golden);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= r.cmd;
      req_if.number <= r.number;
      req_if.left_justify <= r.left_justify;
      req_if.sign_mode <= r.sign_mode;
      req_if.alternate_form <= r.alternate_form;
      req_if.zero_fill <= r.zero_fill;
      req_if.min_width <= r.min_width;
      req_if.min_digits <= r.min_digits;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (r.cmd > ipf_pkg::CMD_HEXU) ignored_sent++;
      else conversions_sent++;
      queue_text(typed ? golden : format_expected(r));
   endtask

   task automatic drain_output();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_text.size() != 0);
   endtask

   // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      char_rec_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_text.size() == 0) begin
            error_count++;
            $display("%0t: unexpected character: expected none, actual %h last %b",
                     $realtime, rsp_if.out_char, rsp_if.last_char);
         end else begin
            want = pending_text.pop_front();
            if (rsp_if.out_char !== want.ch) begin
               error_count++;
               $display("%0t: out_char mismatch: expected %h, actual %h",
                        $realtime, want.ch, rsp_if.out_char);
            end
            if (rsp_if.last_char !== want.last) begin
               error_count++;
               $display("%0t: last_char mismatch: expected %b, actual %b",
                        $realtime, want.last, rsp_if.last_char);
            end
         end
         chars_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d characters outstanding",
                  $realtime, cycle_count, pending_text.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int idle_pct [4];
      int stall_pct [4];
      int sent;
      fmt_req_type r;
      idle_pct = '{0, 65, 0, 38};
      stall_pct = '{0, 0, 65, 38};
      req_if.valid <= 1'b0;
      req_if.cmd <= ipf_pkg::CMD_SDEC;
      req_if.number <= 64'd0;
      req_if.left_justify <= 1'b0;
      req_if.sign_mode <= ipf_pkg::SIGN_NONE;
      req_if.alternate_form <= 1'b0;
      req_if.zero_fill <= 1'b0;
      req_if.min_width <= 7'd0;
      req_if.min_digits <= 7'sd0;

      add_case(ipf_pkg::CMD_SDEC, 64'd0, 0, ipf_pkg::SIGN_NONE, 0, 0, 0, -1, 1, "0");
      add_case(ipf_pkg::CMD_SDEC, '1, 0, ipf_pkg::SIGN_NONE, 0, 0, 0, -1, 1, "-1");
      add_case(ipf_pkg::CMD_SDEC, {1'b1, 63'd0}, 0, ipf_pkg::SIGN_NONE, 0, 0, 0, -1, 1,
               "-9223372036854775808");
      add_case(ipf_pkg::CMD_SDEC, {1'b0, {63{1'b1}}}, 0, ipf_pkg::SIGN_PLUS, 0, 0, 0, -1, 1,
               "+9223372036854775807");
      add_case(ipf_pkg::CMD_SDEC, 64'd42, 0, ipf_pkg::SIGN_SPACE, 0, 0, 0, -1, 1, " 42");
      add_case(ipf_pkg::CMD_SDEC, 64'd5, 0, SIGN_UNUSED, 0, 0, 0, -1, 1, "5");
      add_case(ipf_pkg::CMD_UDEC, '1, 0, ipf_pkg::SIGN_PLUS, 0, 0, 0, -1, 1,
               "18446744073709551615");
      add_case(ipf_pkg::CMD_OCT, 64'd8, 0, ipf_pkg::SIGN_NONE, 1, 0, 0, -1, 1, "010");
      add_case(ipf_pkg::CMD_OCT, 64'd0, 0, ipf_pkg::SIGN_NONE, 1, 0, 0, 0, 1, "0");
      add_case(ipf_pkg::CMD_OCT, 64'd8, 0, ipf_pkg::SIGN_NONE, 1, 0, 0, 5, 1, "00010");
      add_case(ipf_pkg::CMD_OCT, '1, 0, ipf_pkg::SIGN_NONE, 0, 0, 0, -1, 1,
               {"1", "7777777", "7777777", "7777777"});
      add_case(ipf_pkg::CMD_HEXL, 64'hdeadbeef, 0, ipf_pkg::SIGN_NONE, 1, 0, 0, -1, 1,
               "0xdeadbeef");
      add_case(ipf_pkg::CMD_HEXU, 64'hdeadbeef, 0, ipf_pkg::SIGN_NONE, 1, 0, 0, -1, 1,
               "0XDEADBEEF");
      add_case(ipf_pkg::CMD_HEXL, 64'd0, 0, ipf_pkg::SIGN_NONE, 1, 0, 0, 0, 1, "");
      add_case(ipf_pkg::CMD_SDEC, 64'd0, 0, ipf_pkg::SIGN_NONE, 0, 0, 0, 0, 1, "");
      add_case(ipf_pkg::CMD_SDEC, 64'd0, 0, ipf_pkg::SIGN_PLUS, 0, 0, 0, 0, 1, "+");
      add_case(CMD_UNUSED_LO, 64'd123, 0, ipf_pkg::SIGN_NONE, 0, 0, 10, -1, 1, "");
      add_case(CMD_UNUSED_HI, '1, 1, ipf_pkg::SIGN_PLUS, 1, 1, 64, 32, 1, "");
      add_case(ipf_pkg::CMD_UDEC, 64'd42, 0, ipf_pkg::SIGN_NONE, 0, 0, 6, -1, 1, "    42");
      add_case(ipf_pkg::CMD_UDEC, 64'd42, 1, ipf_pkg::SIGN_NONE, 0, 0, 6, -1, 1, "42    ");
      add_case(ipf_pkg::CMD_SDEC, 64'd0 - 64'd42, 0, ipf_pkg::SIGN_NONE, 0, 1, 6, -1, 1,
               "-00042");
      add_case(ipf_pkg::CMD_SDEC, 64'd0 - 64'd42, 1, ipf_pkg::SIGN_NONE, 0, 1, 6, -1, 1,
               "-00042");
      add_case(ipf_pkg::CMD_UDEC, 64'd3, 0, ipf_pkg::SIGN_NONE, 0, 1, 8, 5, 1, "00000003");
      add_case(ipf_pkg::CMD_UDEC, 64'd7, 0, ipf_pkg::SIGN_NONE, 0, 0, 0, 40, 0, "");
      add_case(ipf_pkg::CMD_HEXU, 64'habc, 1, ipf_pkg::SIGN_NONE, 1, 1, 127, 63, 0, "");

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         req_idle_pct = idle_pct[phase];
         rsp_stall_pct = stall_pct[phase];
         if (phase == 0) begin
            foreach (directed_reqs[i])
               send_format(directed_reqs[i], directed_typed[i], directed_text[i]);
         end
         // long receiver hold-off while requests keep coming, so the input backs up
         if (phase == 2) hold_requests++;
         sent = 0;
         while (sent < RANDOM_PER_PHASE) begin
            r = random_request();
            if (r.cmd <= ipf_pkg::CMD_HEXU) sent++;
            send_format(r, 1'b0, "");
         end
         drain_output();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d conversions and %0d unused codes, %0d characters checked,",
               conversions_sent, ignored_sent, chars_checked);
      $display("under free-running, sender-idle, receiver-stall and mixed pacing");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
